[rtl/assert_macros.svh]
// Assertion macros shared by the radix formatter RTL.
// No dependencies; compiled ahead of the package and modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Condition holds at every edge outside reset.
`define SIRF_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Antecedent implies consequent in the same cycle.
`define SIRF_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Antecedent implies consequent in the next cycle.
`define SIRF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SIRF_ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define SIRF_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define SIRF_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[rtl/sirf_pkg.sv]
// Types, constants and helper functions of the radix formatter.
// No dependencies; every RTL module imports it.
`default_nettype none
package sirf_pkg;

   localparam int VALUE_BITS = 16;

   // digit slots: enough for the longest decimal or octal rendering
   localparam int DEC_DIGITS = (VALUE_BITS * 1233) / 4096 + 1;
   localparam int OCT_DIGITS = (VALUE_BITS + 2) / 3;
   localparam int NUM_DIGITS = (DEC_DIGITS > OCT_DIGITS) ? DEC_DIGITS : OCT_DIGITS;
   localparam int DIG_W      = NUM_DIGITS * 4;
   localparam int OCT_W      = NUM_DIGITS * 3;
   localparam int CNT_W      = $clog2(VALUE_BITS + 1);
   localparam int REM_W      = $clog2(NUM_DIGITS + 1);

   localparam logic [2:0] FMT_SDEC = 3'd0;
   localparam logic [2:0] FMT_UDEC = 3'd1;
   localparam logic [2:0] FMT_OCT  = 3'd2;
   localparam logic [2:0] FMT_HEXL = 3'd3;
   localparam logic [2:0] FMT_HEXU = 3'd4;

   localparam logic [1:0] RADIX_DEC = 2'd0;
   localparam logic [1:0] RADIX_OCT = 2'd1;
   localparam logic [1:0] RADIX_HEX = 2'd2;

   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;

   typedef struct packed {
      logic [VALUE_BITS-1:0] value_bits;
      logic [2:0]            opcode;
   } sirf_req_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } sirf_rsp_type;

   typedef struct packed {
      logic       go;
      logic [1:0] radix;
   } sirf_dig_cmd_type;

   typedef struct packed {
      logic             done;
      logic [DIG_W-1:0] digits;
   } sirf_dig_rsp_type;

   typedef struct packed {
      logic load;
      logic neg;
      logic upper;
   } sirf_emit_cmd_type;

   // Octal: 3-bit groups widened to 4-bit digit slots.
   function automatic logic [DIG_W-1:0] oct_digits(input logic [VALUE_BITS-1:0] v);
      logic [OCT_W-1:0] p;
      logic [DIG_W-1:0] r;
      p = OCT_W'(v);
      r = '0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         r[4*i +: 4] = {1'b0, p[3*i +: 3]};
      end
      return r;
   endfunction

   function automatic logic [DIG_W-1:0] hex_digits(input logic [VALUE_BITS-1:0] v);
      return DIG_W'(v);
   endfunction

   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
      logic [7:0] r;
      if (d < 4'd10) begin
         r = CHAR_ZERO + {4'b0000, d};
      end else if (upper) begin
         r = CHAR_UPPER_A + {4'b0000, d - 4'd10};
      end else begin
         r = CHAR_LOWER_A + {4'b0000, d - 4'd10};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

[rtl/sirf_digitize.sv]
// Digit builder: bit-serial shift-add-3 for decimal, direct regrouping for octal/hex.
// Depends on sirf_pkg.
`default_nettype none
module sirf_digitize
   import sirf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  sirf_dig_cmd_type      cmd,
   input  logic [VALUE_BITS-1:0] mag,
   output sirf_dig_rsp_type      rsp
);

   logic [VALUE_BITS-1:0] bin_ff, bin_in;
   logic [DIG_W-1:0]      bcd_ff, bcd_in, adj;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   always_comb begin
      adj = bcd_ff;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end
      end

      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (cmd.go) begin
         unique case (cmd.radix)
            RADIX_DEC: begin
               bin_in  = mag;
               bcd_in  = '0;
               cnt_in  = CNT_W'(VALUE_BITS);
               busy_in = 1'b1;
            end
            RADIX_OCT: begin
               bcd_in  = oct_digits(mag);
               done_in = 1'b1;
            end
            RADIX_HEX: begin
               bcd_in  = hex_digits(mag);
               done_in = 1'b1;
            end
            default: begin
               done_in = 1'b0;
            end
         endcase
      end else if (busy_ff) begin
         // adjust, then shift one bit of the binary value into the BCD word
         bcd_in = {adj[DIG_W-2:0], bin_ff[VALUE_BITS-1]};
         bin_in = {bin_ff[VALUE_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.digits = bcd_ff;

endmodule
`default_nettype wire

[rtl/sirf_emitter.sv]
// Character emitter: leading-zero skip, sign, digit-to-ASCII, output register.
// Depends on sirf_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module sirf_emitter
   import sirf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  sirf_emit_cmd_type cmd,
   input  logic [DIG_W-1:0]  digits,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output sirf_rsp_type      rsp_data,
   output logic              done
);

   localparam logic [1:0] E_IDLE  = 2'd0;
   localparam logic [1:0] E_SKIP  = 2'd1;
   localparam logic [1:0] E_SIGN  = 2'd2;
   localparam logic [1:0] E_DIGIT = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [DIG_W-1:0] dig_ff, dig_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic             neg_ff, neg_in;
   logic             upper_ff, upper_in;
   logic             rsp_valid_ff, rsp_valid_in;
   sirf_rsp_type     rsp_data_ff, rsp_data_in;
   logic [3:0]       top_digit;
   logic             out_free;
   logic             emit;
   sirf_rsp_type     emit_beat;

   assign top_digit = dig_ff[DIG_W-1 -: 4];
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in  = state_ff;
      dig_in    = dig_ff;
      rem_in    = rem_ff;
      neg_in    = neg_ff;
      upper_in  = upper_ff;
      emit      = 1'b0;
      emit_beat = '{char_code: CHAR_ZERO, last_char: 1'b0};
      done      = 1'b0;

      unique case (state_ff)
         E_IDLE: begin
            if (cmd.load) begin
               dig_in   = digits;
               rem_in   = REM_W'(NUM_DIGITS);
               neg_in   = cmd.neg;
               upper_in = cmd.upper;
               state_in = E_SKIP;
            end
         end
         E_SKIP: begin
            // drop leading zeros, keep at least one digit
            if (top_digit == 4'd0 && rem_ff != REM_W'(1)) begin
               dig_in = {dig_ff[DIG_W-5:0], 4'h0};
               rem_in = rem_ff - REM_W'(1);
            end else begin
               state_in = neg_ff ? E_SIGN : E_DIGIT;
            end
         end
         E_SIGN: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_beat = '{char_code: CHAR_MINUS, last_char: 1'b0};
               state_in  = E_DIGIT;
            end
         end
         E_DIGIT: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_beat = '{char_code: digit_char(top_digit, upper_ff),
                             last_char: (rem_ff == REM_W'(1))};
               dig_in    = {dig_ff[DIG_W-5:0], 4'h0};
               rem_in    = rem_ff - REM_W'(1);
               if (rem_ff == REM_W'(1)) begin
                  state_in = E_IDLE;
                  done     = 1'b1;
               end
            end
         end
         default: begin
            state_in = E_IDLE;
         end
      endcase

      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = emit ? emit_beat : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= E_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dig_ff      <= dig_in;
      rem_ff      <= rem_in;
      neg_ff      <= neg_in;
      upper_ff    <= upper_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SIRF_ASSERT_IMPLY(a_load_when_idle, clock, reset, cmd.load, state_ff == E_IDLE, "digits loaded while emitter busy")
   `SIRF_ASSERT_IMPLY(a_digit_left, clock, reset, state_ff == E_DIGIT, rem_ff != '0, "emitting with no digit left")
   `SIRF_ASSERT_NEXT(a_sign_not_last, clock, reset, state_ff == E_SIGN && out_free, rsp_valid_ff && !rsp_data_ff.last_char, "minus sign marked last or lost")

endmodule
`default_nettype wire

[rtl/short_integer_radix_formatter_unit.sv]
// Top level of the radix formatter: request decode, sequencing, sub-unit hookup.
// Depends on sirf_pkg, sirf_digitize, sirf_emitter and assert_macros.svh.
//
// Usage:
//  - Request channel (req_valid/req_stall/req_data) carries one beat per number:
//    a 16-bit pattern and a format code (signed dec, unsigned dec, octal,
//    lowercase hex, uppercase hex). Unused codes are taken and dropped.
//  - Response channel (rsp_valid/rsp_stall/rsp_data) returns one beat per
//    ASCII character, most significant first; last_char flags the final one.
//    Signed decimal negatives lead with a minus sign.
//  - One number is in flight at a time; req_stall is high while it is worked.
//  - Decimal: the magnitude is shifted one bit per cycle through a shift-add-3
//    converter, then leading zeros are skipped one digit per cycle and one
//    character leaves per cycle while the receiver does not stall. Skips and
//    digits always add up to six slots; a minus sign adds one more character.
//    Octal and hex regroup the bits directly, with no serial conversion. The
//    next request is taken once the last character is in the output register.
//  - The last character sits in the output register while the next request is
//    already taken; a stalled receiver holds the beat and pauses emission.
//  - Reset (synchronous, active high) drops any number in flight and empties
//    the output register.
`default_nettype none
`include "assert_macros.svh"
module short_integer_radix_formatter_unit
   import sirf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  sirf_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output sirf_rsp_type rsp_data
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_BUSY = 1'b1;

   logic                  state_ff, state_in;
   logic                  neg_ff, neg_in;
   logic                  upper_ff, upper_in;
   logic                  take;
   logic                  op_ok;
   logic                  is_neg;
   logic                  is_upper;
   logic [1:0]            radix;
   logic [VALUE_BITS-1:0] mag;
   sirf_dig_cmd_type      dig_cmd;
   sirf_dig_rsp_type      dig_rsp;
   sirf_emit_cmd_type     emit_cmd;
   logic                  emit_done;

   assign req_stall = (state_ff == ST_BUSY);
   assign take      = req_valid && !req_stall;

   // Decode the format code.
   always_comb begin
      op_ok    = 1'b1;
      is_upper = 1'b0;
      radix    = RADIX_DEC;
      unique case (req_data.opcode) inside
         FMT_SDEC, FMT_UDEC: radix = RADIX_DEC;
         FMT_OCT:            radix = RADIX_OCT;
         FMT_HEXL:           radix = RADIX_HEX;
         FMT_HEXU: begin
            radix    = RADIX_HEX;
            is_upper = 1'b1;
         end
         default:            op_ok = 1'b0;
      endcase
   end

   // Signed decimal: negate; the most negative pattern maps onto itself,
   // which read unsigned is the right magnitude.
   assign is_neg = (req_data.opcode == FMT_SDEC) && req_data.value_bits[VALUE_BITS-1];
   assign mag    = is_neg ? ((~req_data.value_bits) + VALUE_BITS'(1)) : req_data.value_bits;

   assign dig_cmd = '{go: take && op_ok, radix: radix};

   always_comb begin
      state_in = state_ff;
      neg_in   = neg_ff;
      upper_in = upper_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take && op_ok) begin
               state_in = ST_BUSY;
               neg_in   = is_neg;
               upper_in = is_upper;
            end
         end
         ST_BUSY: begin
            // release once the final character is in the output register
            if (emit_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff   <= neg_in;
      upper_ff <= upper_in;
   end

   sirf_digitize u_digitize (
      .clock (clock),
      .reset (reset),
      .cmd   (dig_cmd),
      .mag   (mag),
      .rsp   (dig_rsp)
   );

   assign emit_cmd = '{load: dig_rsp.done, neg: neg_ff, upper: upper_ff};

   sirf_emitter u_emitter (
      .clock     (clock),
      .reset     (reset),
      .cmd       (emit_cmd),
      .digits    (dig_rsp.digits),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .done      (emit_done)
   );

   `SIRF_ASSERT_IMPLY(a_dig_done_busy, clock, reset, dig_rsp.done, state_ff == ST_BUSY,
                      "digits ready with no number in flight")
   `SIRF_ASSERT_IMPLY(a_emit_done_busy, clock, reset, emit_done, state_ff == ST_BUSY,
                      "emitter finished with no number in flight")
   `SIRF_ASSERT_NEXT(a_take_goes_busy, clock, reset, dig_cmd.go, state_ff == ST_BUSY && req_stall,
                     "accepted number did not block the request channel")

endmodule
`default_nettype wire

[dv/sirf_text_checker.sv]
`timescale 1ns / 1ps
// Checker for the radix formatter: predicts the ASCII text of each accepted number
// and compares every character beat against it. Depends on sirf_pkg only.
module sirf_text_checker
   import sirf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  sirf_req_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  sirf_rsp_type rsp_data,
   output int           failures,
   output int           outstanding,
   output int           numbers_seen,
   output int           chars_checked
);

   sirf_rsp_type pending_chars [$];
   int           fail_tally   = 0;
   int           number_tally = 0;
   int           char_tally   = 0;

   // Append the characters one number should produce, most significant first.
   function automatic void render_number(input sirf_req_type beat);
      logic [VALUE_BITS-1:0] magnitude;
      logic [31:0]           rest;
      int unsigned           base;
      logic                  upper;
      logic                  negative;
      logic [3:0]            digit;
      logic [7:0]            lsb_first [$];
      sirf_rsp_type          ch;
      magnitude = beat.value_bits;
      upper     = 1'b0;
      negative  = 1'b0;
      case (beat.opcode)
         FMT_SDEC: begin
            base = 10;
            if (magnitude[VALUE_BITS-1]) begin
               negative  = 1'b1;
               // the most negative pattern negates onto itself, which is the right magnitude
               magnitude = -magnitude;
            end
         end
         FMT_UDEC: base = 10;
         FMT_OCT:  base = 8;
         FMT_HEXL: base = 16;
         FMT_HEXU: begin
            base  = 16;
            upper = 1'b1;
         end
         default: return;
      endcase
      rest = 32'(magnitude);
      do begin
         digit = 4'(rest % base);
         if (digit < 4'd10) begin
            lsb_first.push_back(CHAR_ZERO + 8'(digit));
         end else if (upper) begin
            lsb_first.push_back(CHAR_UPPER_A + 8'(digit - 4'd10));
         end else begin
            lsb_first.push_back(CHAR_LOWER_A + 8'(digit - 4'd10));
         end
         rest = rest / base;
      end while (rest != 0);
      if (negative) begin
         ch.char_code = CHAR_MINUS;
         ch.last_char = 1'b0;
         pending_chars.push_back(ch);
      end
      for (int k = lsb_first.size() - 1; k >= 0; k--) begin
         ch.char_code = lsb_first[k];
         ch.last_char = (k == 0);
         pending_chars.push_back(ch);
      end
   endfunction

   always @(posedge clock) begin : watch
      sirf_rsp_type want;
      if (!reset) begin
         // check the outgoing character before queuing a new number
         if (rsp_valid && !rsp_stall) begin
            char_tally++;
            if (pending_chars.size() == 0) begin
               fail_tally++;
               if (fail_tally <= 10) begin
                  $display("[%0t] unexpected char %02h last %0b with nothing pending",
                           $realtime, rsp_data.char_code, rsp_data.last_char);
               end
            end else begin
               want = pending_chars.pop_front();
               if (rsp_data.char_code !== want.char_code
                   || rsp_data.last_char !== want.last_char) begin
                  fail_tally++;
                  if (fail_tally <= 10) begin
                     $display("[%0t] char mismatch: expected %02h last %0b, got %02h last %0b",
                              $realtime, want.char_code, want.last_char,
                              rsp_data.char_code, rsp_data.last_char);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            number_tally++;
            render_number(req_data);
         end
      end
      failures      <= fail_tally;
      outstanding   <= pending_chars.size();
      numbers_seen  <= number_tally;
      chars_checked <= char_tally;
   end

endmodule

[dv/tb_short_integer_radix_formatter_unit.sv]
`timescale 1ns / 1ps
// Testbench top for short_integer_radix_formatter_unit: drives numbers and output stalls,
// gives the verdict. Depends on sirf_pkg, the block RTL and sirf_text_checker.
module tb_short_integer_radix_formatter_unit;
   import sirf_pkg::*;

   // format codes the block takes and drops
   localparam logic [2:0] FMT_RSVD_A = 3'd5;
   localparam logic [2:0] FMT_RSVD_B = 3'd6;
   localparam logic [2:0] FMT_RSVD_C = 3'd7;

   localparam int RANDOM_NUMBERS = 277;
   localparam int HOLD_CYCLES    = 300;
   // longest quiet stretch of a correct run is the hold-off plus one number; allow plenty
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 40;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   sirf_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   sirf_rsp_type rsp_data;

   int failures;
   int outstanding;
   int numbers_seen;
   int chars_checked;

   bit no_idle          = 1'b0;  // suppress gaps and stalls on both sides
   bit hold_off_pending = 1'b0;  // ask the receiver for one long hold-off
   int dropped          = 0;
   int idle_cycles      = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   short_integer_radix_formatter_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   sirf_text_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .failures      (failures),
      .outstanding   (outstanding),
      .numbers_seen  (numbers_seen),
      .chars_checked (chars_checked)
   );

   // Offer one number and hold it until the block takes it. Valid only drops
   // when a gap is inserted, so a back-to-back beat keeps valid high.
   task automatic send_number(input logic [VALUE_BITS-1:0] value, input logic [2:0] fmt);
      if (!no_idle && $urandom_range(99) < 15) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_data  <= '{value_bits: value, opcode: fmt};
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (fmt > FMT_HEXU) dropped++;
   endtask

   // Receiver: random stalls, a quiet stretch, and one long hold-off counted here.
   initial begin : receiver
      bit held;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_pending && !held) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (no_idle) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 15);
         end
      end
   end

   // Watchdog: end the run if no beat moves on either channel for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat accepted for %0d cycles", idle_cycles);
            $display("short_integer_radix_formatter_unit verification failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int                    formatted;
      int                    draws;
      logic [VALUE_BITS-1:0] value;
      logic [2:0]            fmt;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: zero in every format, all-ones, sign boundaries, letters, dropped codes
      send_number(16'h0000, FMT_SDEC);
      send_number(16'h0000, FMT_UDEC);
      send_number(16'h0000, FMT_OCT);
      send_number(16'h0000, FMT_HEXL);
      send_number(16'h0000, FMT_HEXU);
      send_number(16'h8000, FMT_SDEC);
      send_number(16'h7FFF, FMT_SDEC);
      send_number(16'hFFFF, FMT_SDEC);
      send_number(16'h0001, FMT_SDEC);
      send_number(16'hFFFF, FMT_UDEC);
      send_number(16'h8000, FMT_UDEC);
      send_number(16'h000A, FMT_UDEC);
      send_number(16'hFFFF, FMT_OCT);
      send_number(16'h8000, FMT_OCT);
      send_number(16'h0007, FMT_OCT);
      send_number(16'hFFFF, FMT_HEXL);
      send_number(16'hABCD, FMT_HEXL);
      send_number(16'hFFFF, FMT_HEXU);
      send_number(16'hABCD, FMT_HEXU);
      send_number(16'h0009, FMT_HEXU);
      send_number(16'h1234, FMT_RSVD_A);
      send_number(16'hFFFF, FMT_RSVD_B);
      send_number(16'h0000, FMT_RSVD_C);

      // random: mostly valid formats, with small values and boundary values mixed in
      formatted = 0;
      draws     = 0;
      while (formatted < RANDOM_NUMBERS) begin
         if (draws == 60) hold_off_pending = 1'b1;
         no_idle = (draws >= 150 && draws < 230);
         if ($urandom_range(99) < 10) begin
            fmt = 3'($urandom_range(FMT_RSVD_A, FMT_RSVD_C));
         end else begin
            fmt = 3'($urandom_range(FMT_SDEC, FMT_HEXU));
         end
         case ($urandom_range(3))
            0:       value = VALUE_BITS'($urandom_range(0, 20));
            1:       value = 16'h8000 ^ VALUE_BITS'($urandom_range(0, 3))
                             ^ ($urandom_range(1) ? 16'h7FFF : 16'h0000);
            default: value = VALUE_BITS'($urandom);
         endcase
         send_number(value, fmt);
         if (fmt <= FMT_HEXU) formatted++;
         draws++;
      end
      no_idle   = 1'b0;
      req_valid <= 1'b0;

      // drain: wait for every predicted character, then let the block settle
      do @(posedge clock); while (outstanding != 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run covered %0d numbers (%0d with reserved codes dropped), %0d characters",
               numbers_seen, dropped, chars_checked);
      $display("over all five formats, random stalls, a no-idle stretch and a %0d-cycle hold-off.",
               HOLD_CYCLES);
      if (failures == 0 && outstanding == 0) begin
         $display("short_integer_radix_formatter_unit verification clean");
      end else begin
         $display("short_integer_radix_formatter_unit verification failed");
      end
      $finish;
   end

endmodule

[short_integer_radix_formatter_unit.f]
+incdir+rtl
rtl/sirf_pkg.sv
rtl/sirf_digitize.sv
rtl/sirf_emitter.sv
rtl/short_integer_radix_formatter_unit.sv
dv/sirf_text_checker.sv
dv/tb_short_integer_radix_formatter_unit.sv
